// File: src/calendar_day_count_converter_defines.svh
// Assertion macros shared by the calendar day count converter RTL.
`ifndef CALENDAR_DAY_COUNT_CONVERTER_DEFINES_SVH
`define CALENDAR_DAY_COUNT_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/cdc_pkg.sv
// Widths, calendar constants and month length table of the day count converter.
package cdc_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 16;
  localparam int LEN_W   = 9;   // holds a year length

  localparam logic [MONTH_W-1:0] MONTHS     = 4'd12;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;  // December, zero based
  localparam logic [LEN_W-1:0]   COMMON_LEN = 9'd365;

  localparam int M100_W = 7;
  localparam int M400_W = 9;
  localparam logic [M100_W-1:0] M100_LAST = 7'd99;
  localparam logic [M400_W-1:0] M400_LAST = 9'd399;

  // Length of a month, zero-based index, with the leap day on February.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
                                                 input logic lp);
    logic [DAY_W-1:0] len;
    unique case (idx)
      4'd1:                      len = lp ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: src/calendar_day_count_converter.sv
// Top level of the Gregorian date to day count converter, both directions.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | mode, in_year, in_month, in_day, in_day_count
//  out     | output    | out_valid_o/out_stall_i | out_day_count, out_year, out_month,
//          |           |                       | out_day, leap, invalid
//
// Walk: one shared add/subtract unit walks the calendar one year, then one
//   month, per cycle. A field that needs no calendar walk to reject goes
//   straight from ST_IDLE to ST_FIN.
// Reset: rst_ni clears the sequencer and the output valid; no clearing pass.
// Stalls: in_stall_o is high from acceptance until the result is loaded; a
//   finished result waits in the output register, and a new item is taken meanwhile.
module calendar_day_count_converter
  import cdc_pkg::*;
#(
  parameter int EPOCH_YEAR = 1970,
  parameter int LAST_YEAR  = 2149
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [YEAR_W-1:0]  in_year_i,
  input  logic [MONTH_W-1:0] in_month_i,
  input  logic [DAY_W-1:0]   in_day_i,
  input  logic [COUNT_W-1:0] in_day_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] out_day_count_o,
  output logic [YEAR_W-1:0]  out_year_o,
  output logic [MONTH_W-1:0] out_month_o,
  output logic [DAY_W-1:0]   out_day_o,
  output logic               leap_o,
  output logic               invalid_o
);

`include "calendar_day_count_converter_defines.svh"

  // Accumulator must hold the full span of years plus one more year before
  // the overflow check, and always at least a 16-bit count with headroom.
  localparam int SPAN  = (LAST_YEAR - EPOCH_YEAR + 1) * 366;
  localparam int ACC_W = $clog2(SPAN + 65536);

  localparam logic [YEAR_W-1:0] EPOCH_Y = YEAR_W'(EPOCH_YEAR);
  localparam logic [YEAR_W-1:0] LAST_Y  = YEAR_W'(LAST_YEAR);
  localparam logic [M100_W-1:0] EPOCH_M100 = M100_W'(EPOCH_YEAR % 100);
  localparam logic [M400_W-1:0] EPOCH_M400 = M400_W'(EPOCH_YEAR % 400);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_YEAR  = 2'd1;
  localparam logic [1:0] ST_MONTH = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               mode_q;
  logic [YEAR_W-1:0]  y_in_q;
  logic [MONTH_W-1:0] m_in_q;
  logic [DAY_W-1:0]   d_in_q;
  logic [COUNT_W-1:0] cnt_in_q;
  logic               bad_q, bad_d;
  logic [YEAR_W-1:0]  yr_q, yr_d;
  logic [M100_W-1:0]  m100_q, m100_d;
  logic [M400_W-1:0]  m400_q, m400_d;
  logic [MONTH_W-1:0] mon_q, mon_d;
  logic [ACC_W-1:0]   acc_q, acc_d;

  logic               out_valid_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic [YEAR_W-1:0]  out_year_q;
  logic [MONTH_W-1:0] out_month_q;
  logic [DAY_W-1:0]   out_day_q;
  logic               out_leap_q;
  logic               out_inv_q;

  logic accept, out_free, out_load;
  logic lp;
  logic [LEN_W-1:0] year_len;
  logic [LEN_W-1:0] mlen;

  // Shared unit: one add or subtract on the accumulator, borrow as compare.
  logic [LEN_W-1:0] alu_op;
  logic             alu_sub;
  logic [ACC_W:0]   alu_res;
  logic             alu_ge;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_FIN) && out_free;

  assign in_stall_o = (state_q != ST_IDLE);

  // Leap rule from the running year and its mod 100 / mod 400 counters.
  assign lp       = (yr_q[1:0] == 2'd0) && ((m400_q == '0) || (m100_q != '0));
  assign year_len = COMMON_LEN + {{(LEN_W-1){1'b0}}, lp};
  assign mlen     = {{(LEN_W-DAY_W){1'b0}}, month_len(mon_q, lp)};

  always_comb begin
    alu_sub = mode_q;
    if (state_q == ST_YEAR) begin
      alu_op = year_len;
    end else if (!mode_q && (mon_q + 4'd1 == m_in_q)) begin
      alu_op = {{(LEN_W-DAY_W){1'b0}}, d_in_q - 5'd1};
    end else begin
      alu_op = mlen;
    end
    if (alu_sub) begin
      alu_res = {1'b0, acc_q} - {{(ACC_W+1-LEN_W){1'b0}}, alu_op};
    end else begin
      alu_res = {1'b0, acc_q} + {{(ACC_W+1-LEN_W){1'b0}}, alu_op};
    end
    alu_ge = !alu_res[ACC_W];
  end

  always_comb begin
    state_d = state_q;
    bad_d   = bad_q;
    yr_d    = yr_q;
    m100_d  = m100_q;
    m400_d  = m400_q;
    mon_d   = mon_q;
    acc_d   = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          yr_d   = EPOCH_Y;
          m100_d = EPOCH_M100;
          m400_d = EPOCH_M400;
          mon_d  = '0;
          acc_d  = mode_i ? {{(ACC_W-COUNT_W){1'b0}}, in_day_count_i} : '0;
          // Fields that need no calendar walk to reject.
          bad_d  = !mode_i && ((in_year_i < EPOCH_Y) || (in_year_i > LAST_Y) ||
                               (in_month_i == '0) || (in_month_i > MONTHS) ||
                               (in_day_i == '0));
          state_d = bad_d ? ST_FIN : ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (mode_q ? alu_ge : (yr_q != y_in_q)) begin
          // Advance one year.
          acc_d  = alu_res[ACC_W-1:0];
          yr_d   = yr_q + 12'd1;
          m100_d = (m100_q == M100_LAST) ? '0 : m100_q + 7'd1;
          m400_d = (m400_q == M400_LAST) ? '0 : m400_q + 9'd1;
        end else if (mode_q) begin
          bad_d   = (yr_q > LAST_Y);
          state_d = bad_d ? ST_FIN : ST_MONTH;
        end else begin
          // Day range needs the leap flag of the target year.
          bad_d   = (d_in_q > month_len(m_in_q - 4'd1, lp));
          state_d = bad_d ? ST_FIN : ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (mode_q) begin
          if ((mon_q < LAST_MONTH) && alu_ge) begin
            acc_d = alu_res[ACC_W-1:0];
            mon_d = mon_q + 4'd1;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          acc_d = alu_res[ACC_W-1:0];
          if (mon_q + 4'd1 == m_in_q) begin
            state_d = ST_FIN;  // day offset added this cycle
          end else begin
            mon_d = mon_q + 4'd1;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      y_in_q   <= in_year_i;
      m_in_q   <= in_month_i;
      d_in_q   <= in_day_i;
      cnt_in_q <= in_day_count_i;
    end
    bad_q  <= bad_d;
    yr_q   <= yr_d;
    m100_q <= m100_d;
    m400_q <= m400_d;
    mon_q  <= mon_d;
    acc_q  <= acc_d;
  end

  // Result register; a count that spills past 16 bits is rejected here.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (bad_q || (!mode_q && (|acc_q[ACC_W-1:COUNT_W]))) begin
        out_cnt_q   <= '0;
        out_year_q  <= '0;
        out_month_q <= '0;
        out_day_q   <= '0;
        out_leap_q  <= 1'b0;
        out_inv_q   <= 1'b1;
      end else if (!mode_q) begin
        out_cnt_q   <= acc_q[COUNT_W-1:0];
        out_year_q  <= y_in_q;
        out_month_q <= m_in_q;
        out_day_q   <= d_in_q;
        out_leap_q  <= lp;
        out_inv_q   <= 1'b0;
      end else begin
        out_cnt_q   <= cnt_in_q;
        out_year_q  <= yr_q;
        out_month_q <= mon_q + 4'd1;
        out_day_q   <= acc_q[DAY_W-1:0] + 5'd1;
        out_leap_q  <= lp;
        out_inv_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_day_count_o = out_cnt_q;
  assign out_year_o      = out_year_q;
  assign out_month_o     = out_month_q;
  assign out_day_o       = out_day_q;
  assign leap_o          = out_leap_q;
  assign invalid_o       = out_inv_q;

  `CDC_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "item accepted but sequencer idle")
  `CDC_ASSERT_NOW(a_month_range, state_q == ST_MONTH, mon_q < MONTHS, "month walk past December")
  `CDC_ASSERT_NOW(a_invalid_zero, out_valid_o && invalid_o, (out_day_count_o == '0) && (out_year_o == '0) && (out_month_o == '0) && (out_day_o == '0) && !leap_o, "invalid result with nonzero fields")
  `CDC_ASSERT_NOW(a_valid_date, out_valid_o && !invalid_o, (out_month_o != '0) && (out_month_o <= MONTHS) && (out_day_o != '0), "valid result with bad month or day")

endmodule

// File: test/tb_calendar_day_count_converter.sv
// Self-checking testbench of the calendar day count converter, both conversion directions.
module tb_calendar_day_count_converter;
  import cdc_pkg::YEAR_W;
  import cdc_pkg::MONTH_W;
  import cdc_pkg::DAY_W;
  import cdc_pkg::COUNT_W;

  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned LAST_YEAR     = 2149;
  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned SETTLE_CYCLES = 250;      // a little over the longest walk
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned PRINT_CAP     = 50;

  typedef enum logic {
    TO_COUNT = 1'b0,
    TO_DATE  = 1'b1
  } conv_mode_e;

  typedef struct {
    conv_mode_e         mode;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [COUNT_W-1:0] day_count;
    int unsigned        gap;     // idle cycles before this item is offered
    bit                 drain;   // hold this item until every result is back
  } conv_req_t;

  typedef struct {
    logic [COUNT_W-1:0] day_count;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               leap;
    logic               invalid;
  } conv_res_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               mode_i         = 1'b0;
  logic [YEAR_W-1:0]  in_year_i      = '0;
  logic [MONTH_W-1:0] in_month_i     = '0;
  logic [DAY_W-1:0]   in_day_i       = '0;
  logic [COUNT_W-1:0] in_day_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [COUNT_W-1:0] out_day_count_o;
  logic [YEAR_W-1:0]  out_year_o;
  logic [MONTH_W-1:0] out_month_o;
  logic [DAY_W-1:0]   out_day_o;
  logic               leap_o;
  logic               invalid_o;

  conv_req_t   request_q[$];   // items still to be offered
  conv_res_t   conv_due_q[$];  // conversions owed by the block, oldest first
  conv_req_t   cur_req;
  int unsigned idle_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_got  = 0;
  int unsigned to_count_cnt = 0;
  int unsigned to_date_cnt  = 0;
  int unsigned invalid_cnt  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned total_items  = 0;

  calendar_day_count_converter #(
    .EPOCH_YEAR(EPOCH_YEAR),
    .LAST_YEAR (LAST_YEAR)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .in_year_i      (in_year_i),
    .in_month_i     (in_month_i),
    .in_day_i       (in_day_i),
    .in_day_count_i (in_day_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_day_count_o(out_day_count_o),
    .out_year_o     (out_year_o),
    .out_month_o    (out_month_o),
    .out_day_o      (out_day_o),
    .leap_o         (leap_o),
    .invalid_o      (invalid_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic of the predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned yr);
    return (yr % 4 == 0) && ((yr % 400 == 0) || (yr % 100 != 0));
  endfunction

  function automatic int unsigned days_of_year(int unsigned yr);
    return is_leap(yr) ? 366 : 365;
  endfunction

  // Zero-based month index; the leap day lands on February only.
  function automatic int unsigned days_of_month(int unsigned idx, bit lp);
    case (idx % 12)
      1:           return lp ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // Work out the one result an item owes. Any rejected case zeroes every field
  // but the invalid flag.
  function automatic conv_res_t convert(conv_req_t req);
    conv_res_t   res;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned total;
    bit          lp;
    res = '{default: '0};
    if (req.mode == TO_COUNT) begin
      yr = 32'(req.year);
      mo = 32'(req.month);
      dy = 32'(req.day);
      lp = is_leap(yr);
      if (yr < EPOCH_YEAR || yr > LAST_YEAR || mo < 1 || mo > 12 ||
          dy < 1 || dy > days_of_month(mo - 1, lp)) begin
        res.invalid = 1'b1;
        return res;
      end
      total = dy - 1;
      for (int unsigned y = EPOCH_YEAR; y < yr; y++) total += days_of_year(y);
      for (int unsigned m = 0; m + 1 < mo; m++) total += days_of_month(m, lp);
      // a valid date late in the last year can still overflow the count
      if (total > 32'hFFFF) begin
        res.invalid = 1'b1;
        return res;
      end
      res.day_count = total[COUNT_W-1:0];
      res.year      = req.year;
      res.month     = req.month;
      res.day       = req.day;
      res.leap      = lp;
    end else begin
      total = 32'(req.day_count);
      yr    = EPOCH_YEAR;
      mo    = 0;
      while (total >= days_of_year(yr)) begin
        total -= days_of_year(yr);
        yr++;
      end
      if (yr > LAST_YEAR) begin
        res.invalid = 1'b1;
        return res;
      end
      lp = is_leap(yr);
      while (mo < 11 && total >= days_of_month(mo, lp)) begin
        total -= days_of_month(mo, lp);
        mo++;
      end
      res.day_count = req.day_count;
      res.year      = yr[YEAR_W-1:0];
      res.month     = 4'(mo + 1);
      res.day       = 5'(total + 1);
      res.leap      = lp;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  // Attach pacing: stretches of back-to-back items, otherwise a random gap.
  // Every 300th item waits for the block to drain completely.
  task automatic queue_item(conv_req_t req);
    int unsigned idx;
    idx       = request_q.size();
    req.gap   = ((idx / 120) % 4 == 3) ? 0 : $urandom_range(0, 3);
    req.drain = (idx % 300 == 299);
    request_q.push_back(req);
  endtask

  // Date to count; the unused count field carries noise.
  task automatic add_date(int unsigned yr, int unsigned mo, int unsigned dy);
    conv_req_t req;
    req.mode      = TO_COUNT;
    req.year      = yr[YEAR_W-1:0];
    req.month     = mo[MONTH_W-1:0];
    req.day       = dy[DAY_W-1:0];
    req.day_count = COUNT_W'($urandom_range(0, 65535));
    queue_item(req);
  endtask

  // Count to date; the unused date fields carry noise.
  task automatic add_count(int unsigned cnt);
    conv_req_t req;
    req.mode      = TO_DATE;
    req.year      = YEAR_W'($urandom_range(0, 4095));
    req.month     = MONTH_W'($urandom_range(0, 15));
    req.day       = DAY_W'($urandom_range(0, 31));
    req.day_count = cnt[COUNT_W-1:0];
    queue_item(req);
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting: one line per mismatch, printing capped, always counted
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < PRINT_CAP)
      $display("mismatch at result %0d: %s got %0h, expected %0h",
               results_got, what, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued items, hold the payload while stalled, idle per item
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned wait_left;
    int unsigned sent_now;
    bit          free;
    bit          offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left  <= 0;
    end else begin
      offer = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        // item taken: owe its result, count it, load the next item's gap
        conv_due_q.push_back(convert(cur_req));
        accepted_cnt <= accepted_cnt + 1;
        if (cur_req.mode == TO_COUNT) to_count_cnt <= to_count_cnt + 1;
        else                          to_date_cnt  <= to_date_cnt + 1;
        sent_now  = accepted_cnt + 1;
        wait_left = (request_q.size() != 0) ? request_q[0].gap : 0;
        free      = 1'b1;
      end else begin
        sent_now  = accepted_cnt;
        wait_left = idle_left;
        free      = !in_valid_i;
      end
      if (free) begin
        if (wait_left != 0) begin
          wait_left--;
        end else if (request_q.size() != 0 &&
                     (!request_q[0].drain || sent_now == results_got)) begin
          cur_req        = request_q.pop_front();
          mode_i         <= cur_req.mode;
          in_year_i      <= cur_req.year;
          in_month_i     <= cur_req.month;
          in_day_i       <= cur_req.day;
          in_day_count_i <= cur_req.day_count;
          offer          = 1'b1;
        end
        // one assignment per edge keeps back-to-back items high throughout
        in_valid_i <= offer;
      end
      idle_left <= wait_left;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, check every taken result against the oldest owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    conv_res_t   want;
    int unsigned hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      hold = stall_left;
      if (out_valid_o && !out_stall_i) begin
        results_got <= results_got + 1;
        if (invalid_o === 1'b1) invalid_cnt <= invalid_cnt + 1;
        if (conv_due_q.size() == 0) begin
          report_mismatch("result with nothing owed, count", 32'(out_day_count_o), '0);
        end else begin
          want = conv_due_q.pop_front();
          if (out_day_count_o !== want.day_count)
            report_mismatch("day count", 32'(out_day_count_o), 32'(want.day_count));
          if (out_year_o !== want.year)
            report_mismatch("year", 32'(out_year_o), 32'(want.year));
          if (out_month_o !== want.month)
            report_mismatch("month", 32'(out_month_o), 32'(want.month));
          if (out_day_o !== want.day)
            report_mismatch("day", 32'(out_day_o), 32'(want.day));
          if (leap_o !== want.leap)
            report_mismatch("leap", 32'(leap_o), 32'(want.leap));
          if (invalid_o !== want.invalid)
            report_mismatch("invalid", 32'(invalid_o), 32'(want.invalid));
        end
        // draw the stall ahead of the next result; drop it in calm stretches
        hold = ((results_got / 100) % 4 == 1) ? 0 : $urandom_range(0, 3);
      end else if (hold != 0) begin
        hold--;
      end
      stall_left  <= hold;
      out_stall_i <= (hold != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;

    // Date to count: epoch start and end of its first year
    add_date(1970, 1, 1);
    add_date(1970, 12, 31);
    // leap day in a plain leap year, a common year, a 400 year and a 100 year
    add_date(1972, 2, 29);
    add_date(1973, 2, 29);
    add_date(2000, 2, 29);
    add_date(2100, 2, 29);
    add_date(2100, 3, 1);
    // last date whose count fits in 16 bits, the day after, end of last year
    add_date(2149, 6, 6);
    add_date(2149, 6, 7);
    add_date(2149, 12, 31);
    // years out of range at both ends and at the field extremes
    add_date(1969, 12, 31);
    add_date(2150, 1, 1);
    add_date(0, 1, 1);
    add_date(4095, 15, 31);
    // bad months and days, and the last day of January
    add_date(2000, 0, 1);
    add_date(2000, 13, 1);
    add_date(2000, 6, 0);
    add_date(2001, 4, 31);
    add_date(2001, 1, 31);
    // Count to date: zero, largest count, March 1 1970, around the first leap day, start of the last year
    add_count(0);
    add_count(65535);
    add_count(59);
    add_count(789);
    add_count(790);
    add_count(65379);

    // Random part: mostly well-formed dates and counts, some noise
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        add_date($urandom_range(EPOCH_YEAR, LAST_YEAR), $urandom_range(1, 12),
                 $urandom_range(1, 31));
      else if (pick < 47)
        add_date(LAST_YEAR, $urandom_range(5, 7), $urandom_range(1, 31));
      else if (pick < 57)
        add_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
      else if (pick < 85)
        add_count($urandom_range(0, 65535));
      else if (pick < 93)
        add_count($urandom_range(0, 1500));
      else
        add_count($urandom_range(64800, 65535));
    end
    total_items = request_q.size();

    // hold reset, then release it away from the active edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (accepted_cnt != total_items || results_got < accepted_cnt) @(posedge clk_i);
    // let any stray result show up before closing
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (conv_due_q.size() != 0)
      report_mismatch("results never delivered", conv_due_q.size(), '0);

    $display("checked %0d conversions: %0d date to count, %0d count to date",
             results_got, to_count_cnt, to_date_cnt);
    $display("%0d results flagged invalid, %0d mismatches", invalid_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_calendar_day_count_converter OK");
    end else begin
      $display("tb_calendar_day_count_converter NOT OK");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("timeout: %0d of %0d items taken, %0d results", accepted_cnt, total_items,
             results_got);
    $display("tb_calendar_day_count_converter NOT OK");
    $finish;
  end

endmodule
